// File: design/oara_pkg.sv
package oara_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int OFFSET_W  = 12;
  localparam int COUNT_W   = 12;
  localparam int OP_W      = 3;
  localparam int LEN_CFG_W = 13;
  localparam int IN_DATA_W = 56;

  // Bit positions of the input fields inside s_axis_tdata.
  localparam int OFFSET_LSB = 0;
  localparam int SAMPLE_LSB = OFFSET_LSB + OFFSET_W;
  localparam int COUNT_LSB  = SAMPLE_LSB + SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ACCUMULATE   = 3'd0,
    OP_READ_SUM     = 3'd1,
    OP_READ_CURRENT = 3'd2,
    OP_ADVANCE      = 3'd3,
    OP_CLEAR        = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_ADD,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// File: design/overlap_add_ring_accumulator_top.sv
// Accumulate and read_sum reduce position + offset modulo the length, where SW is the width
// of position + offset (13 for DEPTH 4096); the modulo takes one bit per cycle in a shared
// restoring remainder unit. Read_current outside the ring answers zero without a read; unknown codes answer zero.
// Advance clears min(count, length) entries and clear clears length entries, one entry per cycle.
// One item is in work at a time; the next is taken in the cycle after the result is loaded.
// After reset the store is zeroed entry by entry in a pass during which no item is accepted.
module overlap_add_ring_accumulator_top import oara_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [LEN_CFG_W-1:0] cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // offset [11:0], sample [43:12], count [55:44]
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // operation [2:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // value [31:0]
  output logic [SAMPLE_W-1:0]  m_axis_tdata,
  output logic                 m_axis_tlast
);

  localparam int AW   = $clog2(DEPTH);
  localparam int LW   = $clog2(DEPTH + 1);
  localparam int RW   = AW + 1;
  localparam int SW   = ((AW > OFFSET_W) ? AW : OFFSET_W) + 1;
  localparam int CNTW = $clog2(SW);
  localparam int CMPW = (LW > COUNT_W) ? LW : COUNT_W;

  state_t state, state_next;
  op_t    op, op_in;

  logic [AW-1:0]       rp;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       addr_inc;
  logic [LW-1:0]       len, len_cfg;
  logic [LW-1:0]       n, nmin;
  logic [SAMPLE_W-1:0] sample_r;
  logic [COUNT_W-1:0]  count_r;
  logic                fin;
  logic [SAMPLE_W-1:0] res_val;

  logic [SW-1:0]   dvd;
  logic [AW-1:0]   rem, rem_step;
  logic [CNTW-1:0] cnt;
  logic            mod_pos;
  logic            mod_last;
  logic [RW-1:0]   trial, trial_sub;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic                mem_we;
  logic [SAMPLE_W-1:0] mem_wdata;

  logic [SAMPLE_W:0]   sum_wide;
  logic [SAMPLE_W-1:0] sat_sum;

  logic accept, out_free, load_out;

  assign op_in    = op_t'(s_axis_tuser);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign mod_last = (cnt == '0);

  always_comb begin
    if (cfg_wdata == '0) begin
      len_cfg = LW'(1);
    end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
      len_cfg = LW'(DEPTH);
    end else begin
      len_cfg = LW'(cfg_wdata);
    end
  end

  // One step of the restoring remainder: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {rem, dvd[SW-1]};
    trial_sub = trial - RW'(len);
    rem_step  = (trial >= RW'(len)) ? trial_sub[AW-1:0] : trial[AW-1:0];
  end

  always_comb begin
    if (CMPW'(count_r) < CMPW'(len)) begin
      nmin = LW'(count_r);
    end else begin
      nmin = len;
    end
  end

  assign addr_inc = (RW'(addr) + RW'(1) == RW'(len)) ? '0 : addr + AW'(1);

  always_comb begin
    sum_wide = {sample_r[SAMPLE_W-1], sample_r} + {rd_data[SAMPLE_W-1], rd_data};
    if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1]) begin
      sat_sum = sum_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      sat_sum = sum_wide[SAMPLE_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_ACCUMULATE, OP_READ_SUM, OP_ADVANCE: state_next = ST_MOD;
            OP_READ_CURRENT: state_next = (RW'(rp) < RW'(len)) ? ST_READ : ST_DONE;
            OP_CLEAR:        state_next = ST_WALK;
            default:         state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_last) begin
          if (mod_pos) begin
            state_next = ST_DONE;
          end else if (op == OP_ADVANCE) begin
            state_next = (nmin == '0) ? ST_MOD : ST_WALK;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_ADD;
      ST_ADD:  state_next = ST_DONE;
      ST_WALK: begin
        if (n == LW'(1)) state_next = (op == OP_ADVANCE) ? ST_MOD : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    load_out      = 1'b0;
    unique case (state)
      ST_INIT: mem_we = 1'b1;
      ST_IDLE: s_axis_tready = 1'b1;
      ST_ADD: begin
        if (op == OP_ACCUMULATE) begin
          mem_we    = 1'b1;
          mem_wdata = sat_sum;
        end
      end
      ST_WALK: mem_we = 1'b1;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      rp            <= '0;
      len           <= LW'(DEPTH);
      addr          <= '0;
      mod_pos       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      m_axis_tvalid <= load_out || (m_axis_tvalid && !m_axis_tready);
      if (cfg_we) len <= len_cfg;
      unique case (state)
        ST_INIT: addr <= addr + AW'(1);
        ST_IDLE: begin
          if (accept) begin
            mod_pos <= 1'b0;
            if (op_in == OP_CLEAR) begin
              rp   <= '0;
              addr <= '0;
            end else if (op_in == OP_READ_CURRENT) begin
              addr <= rp;
            end
          end
        end
        ST_MOD: begin
          if (mod_last) begin
            if (mod_pos) begin
              rp <= rem_step;
            end else begin
              addr <= rem_step;
              if (op == OP_ADVANCE && nmin == '0) mod_pos <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          addr <= addr_inc;
          if (n == LW'(1) && op == OP_ADVANCE) mod_pos <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op       <= op_in;
          sample_r <= s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
          count_r  <= s_axis_tdata[COUNT_LSB +: COUNT_W];
          fin      <= s_axis_tlast;
          res_val  <= '0;
          rem      <= '0;
          cnt      <= CNTW'(SW - 1);
          n        <= len;
          if (op_in == OP_ADVANCE) begin
            dvd <= SW'(rp);
          end else begin
            dvd <= SW'(rp) + SW'(s_axis_tdata[OFFSET_LSB +: OFFSET_W]);
          end
        end
      end
      ST_MOD: begin
        if (mod_last && !mod_pos && op == OP_ADVANCE && nmin == '0) begin
          // Nothing to clear: go straight to the new position.
          dvd <= SW'(rp) + SW'(count_r);
          rem <= '0;
          cnt <= CNTW'(SW - 1);
        end else begin
          dvd <= dvd << 1;
          rem <= rem_step;
          cnt <= cnt - CNTW'(1);
          if (mod_last && !mod_pos && op == OP_ADVANCE) n <= nmin;
        end
      end
      ST_ADD: begin
        if (op == OP_READ_SUM) begin
          res_val <= sat_sum;
        end else if (op == OP_READ_CURRENT) begin
          res_val <= rd_data;
        end
      end
      ST_WALK: begin
        n <= n - LW'(1);
        if (n == LW'(1) && op == OP_ADVANCE) begin
          dvd <= SW'(rp) + SW'(count_r);
          rem <= '0;
          cnt <= CNTW'(SW - 1);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          m_axis_tdata <= res_val;
          m_axis_tlast <= fin;
        end
      end
      default: ;
    endcase
  end

  // A finished result must not overwrite one that is still waiting.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_axis_tvalid && !m_axis_tready) |=> state == ST_DONE)
    else $error("result left DONE while output was stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> state != ST_IDLE && !s_axis_tready)
    else $error("item accepted without leaving idle");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> n != '0)
    else $error("clearing walk with zero entries left");

  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_MOD && $past(mod_pos) && $past(cnt) == '0)
      |-> RW'(rp) < RW'($past(len)))
    else $error("new read position outside the ring");

endmodule

// File: verif/testbench.sv
module testbench;
  import oara_pkg::*;

  localparam int RING_DEPTH = 4096;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_CLEAR + OP_W'(1);
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

  typedef struct {
    logic [OP_W-1:0]            op;
    logic [OFFSET_W-1:0]        offset;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]         count;
    logic                       fin;
  } ring_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       fin;
  } ring_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [LEN_CFG_W-1:0] cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  // Shadow of the ring store, its position and the length in use.
  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  int ring_pos = 0;
  int ring_len = RING_DEPTH;

  ring_item_t   ring_pending [$];
  ring_result_t ring_expect [$];
  ring_item_t   tx_item;
  int           items_queued = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_hold = 0;
  bit           rx_hold_done = 0;
  bit           no_idle = 0;

  overlap_add_ring_accumulator_top #(.DEPTH(RING_DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] q823_sat_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    longint s;
    longint hi;
    longint lo;
    s  = longint'(a) + longint'(b);
    hi = longint'($signed(SAMPLE_MAX));
    lo = longint'($signed(SAMPLE_MIN));
    if (s > hi) return SAMPLE_MAX;
    if (s < lo) return SAMPLE_MIN;
    return s[SAMPLE_W-1:0];
  endfunction

  task automatic step_ring(input ring_item_t it, output ring_result_t r);
    int at;
    int n;
    r.value = '0;
    r.fin   = it.fin;
    case (it.op)
      OP_ACCUMULATE: begin
        at = (ring_pos + int'(it.offset)) % ring_len;
        ring_mem[at] = q823_sat_add(ring_mem[at], it.sample);
      end
      OP_READ_SUM: begin
        at = (ring_pos + int'(it.offset)) % ring_len;
        r.value = q823_sat_add(it.sample, ring_mem[at]);
      end
      OP_READ_CURRENT: begin
        if (ring_pos < ring_len) r.value = ring_mem[ring_pos];
      end
      OP_ADVANCE: begin
        n = (int'(it.count) < ring_len) ? int'(it.count) : ring_len;
        for (int i = 0; i < n; i++) ring_mem[(ring_pos + i) % ring_len] = '0;
        ring_pos = (ring_pos + int'(it.count)) % ring_len;
      end
      OP_CLEAR: begin
        ring_pos = 0;
        for (int i = 0; i < ring_len; i++) ring_mem[i] = '0;
      end
      default: ;
    endcase
  endtask

  // Driver: offers pending items, predicts each one as it is accepted.
  always @(posedge clk) begin
    ring_result_t r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_ring(tx_item, r);
        ring_expect.push_back(r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 13);
          s_axis_tvalid <= 1'b0;
        end else if (ring_pending.size() > 0) begin
          tx_item = ring_pending.pop_front();
          s_axis_tdata  <= {tx_item.count, tx_item.sample, tx_item.offset};
          s_axis_tuser  <= tx_item.op;
          s_axis_tlast  <= tx_item.fin;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off lets the input side back up behind a full block.
  always @(posedge clk) begin
    if (!rst) begin
      if (!rx_hold_done && results_seen >= 150) begin
        rx_hold_done <= 1'b1;
        rx_hold      <= 300;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // Monitor: checks each accepted result and paces the output side.
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (ring_expect.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value %h last %b", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = ring_expect.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tlast !== want.fin) begin
            if (mismatches < 10)
              $display("result %0d: value %h expected %h, last %b expected %b",
                       results_seen, m_axis_tdata, want.value, m_axis_tlast, want.fin);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_ring_item(input logic [OP_W-1:0] op, input int unsigned offset,
                                 input logic signed [SAMPLE_W-1:0] sample,
                                 input int unsigned count, input logic fin);
    ring_item_t it;
    it.op     = op;
    it.offset = offset[OFFSET_W-1:0];
    it.sample = sample;
    it.count  = count[COUNT_W-1:0];
    it.fin    = fin;
    ring_pending.push_back(it);
    items_queued++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return {{8{r[23]}}, r[23:0]};
      default: return r;
    endcase
  endfunction

  // Overlap-add frame: add into k slots, read them back as a run, move on.
  task automatic queue_overlap_frame(input int len);
    int k;
    int base;
    k    = $urandom_range(1, (len < 12) ? len : 12);
    base = $urandom_range(0, len - 1);
    for (int i = 0; i < k; i++)
      queue_ring_item(OP_ACCUMULATE, base + i, random_sample(), $urandom,
                      1'($urandom_range(0, 1)));
    for (int i = 0; i < k; i++)
      queue_ring_item(OP_READ_SUM, base + i, random_sample(), $urandom, i == k - 1);
    if ($urandom_range(0, 1) == 0)
      queue_ring_item(OP_READ_CURRENT, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    queue_ring_item(OP_ADVANCE, $urandom, $urandom,
                    ($urandom_range(0, 3) == 0) ? base + k : k, 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_noise_item();
    queue_ring_item(OP_W'($urandom_range(0, int'(OP_SPARE_LAST))),
                    $urandom_range(0, RING_DEPTH - 1),
                    random_sample(),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40),
                    1'($urandom_range(0, 1)));
  endtask

  task automatic await_ring_idle();
    do @(negedge clk);
    while (ring_pending.size() != 0 || s_axis_tvalid || ring_expect.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_ring_length(input int unsigned len);
    await_ring_idle();
    cfg_wdata <= len[LEN_CFG_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (len[LEN_CFG_W-1:0] > RING_DEPTH) ring_len = RING_DEPTH;
    else if (len[LEN_CFG_W-1:0] == 0) ring_len = 1;
    else ring_len = int'(len[LEN_CFG_W-1:0]);
  endtask

  initial begin
    int lengths [12];
    int start;
    lengths = '{37, 1, 5000, 16, 0, 200, 8191, 3, 64, 4096, 2, 24};
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Saturation at both rails, spare codes, and an advance that clears all but one entry of the ring.
    queue_ring_item(OP_READ_CURRENT, 0, 0, 0, 1'b0);
    queue_ring_item(OP_ACCUMULATE, 0, SAMPLE_MAX, 0, 1'b0);
    queue_ring_item(OP_ACCUMULATE, 0, 1, 0, 1'b0);
    queue_ring_item(OP_READ_SUM, 0, SAMPLE_MAX, 0, 1'b1);
    queue_ring_item(OP_ACCUMULATE, 4095, SAMPLE_MIN, 4095, 1'b0);
    queue_ring_item(OP_ACCUMULATE, 4095, -1, 0, 1'b0);
    queue_ring_item(OP_READ_SUM, 4095, SAMPLE_MIN, 0, 1'b1);
    queue_ring_item(OP_SPARE_FIRST, 4095, SAMPLE_MAX, 4095, 1'b1);
    queue_ring_item(OP_SPARE_FIRST + OP_W'(1), 0, 0, 0, 1'b0);
    queue_ring_item(OP_SPARE_LAST, 4095, -1, 4095, 1'b1);
    queue_ring_item(OP_ACCUMULATE, 10, 32'h0123_4567, 0, 1'b0);
    queue_ring_item(OP_ADVANCE, 0, 0, 5, 1'b0);
    queue_ring_item(OP_READ_SUM, 5, 1, 0, 1'b1);
    queue_ring_item(OP_ADVANCE, 0, 0, 4095, 1'b0);
    queue_ring_item(OP_ADVANCE, 0, 0, 3000, 1'b0);
    queue_ring_item(OP_ACCUMULATE, 0, 777, 0, 1'b0);

    // Shrink below the position: read_current answers zero, counts exceed the ring.
    set_ring_length(100);
    queue_ring_item(OP_READ_CURRENT, 0, 0, 0, 1'b1);
    queue_ring_item(OP_ACCUMULATE, 7, -5, 0, 1'b0);
    queue_ring_item(OP_READ_SUM, 7, 0, 0, 1'b1);
    queue_ring_item(OP_ADVANCE, 0, 0, 4000, 1'b0);

    // Grow back: the entry outside the short ring must still hold its value.
    set_ring_length(RING_DEPTH);
    queue_ring_item(OP_READ_SUM, 3000, 0, 0, 1'b1);
    queue_ring_item(OP_CLEAR, 0, 0, 0, 1'b0);

    set_ring_length(0);
    queue_ring_item(OP_ACCUMULATE, 4095, SAMPLE_MAX, 0, 1'b0);
    queue_ring_item(OP_READ_CURRENT, 0, 0, 0, 1'b1);
    queue_ring_item(OP_ADVANCE, 0, 0, 4095, 1'b0);

    foreach (lengths[p]) begin
      set_ring_length(lengths[p]);
      if (p == $size(lengths) - 1) no_idle = 1;
      start = items_queued;
      while (items_queued - start < 105) begin
        if ($urandom_range(0, 9) < 7) queue_overlap_frame(ring_len);
        else queue_noise_item();
      end
    end

    await_ring_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && ring_expect.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #(12 * 20000000);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
